### sv/thmr_pkg.sv
package thmr_pkg;

  localparam int CmdW    = 10;
  localparam int RemapW  = 11;
  localparam int MixW    = 14;
  localparam int SpanW   = 10;
  localparam int RcpW    = 17;
  localparam int RcpShift = 24;
  localparam int AccW    = 25;
  localparam int MagW    = 24;
  localparam int QuotW   = 17;
  localparam int MulAW   = 25;
  localparam int MulBW   = 18;
  localparam int ProdW   = MulAW + MulBW;
  localparam int RemW    = 28;
  localparam int OutW    = 16;
  localparam int NumThr  = 5;
  localparam int InDataW = 56;
  localparam int OutDataW = NumThr * OutW;

  localparam logic signed [RemapW-1:0] FwdOutLow = 11'sd0;

  typedef enum logic [2:0] {
    RegBase      = 3'd0,
    RegFwdTrim   = 3'd1,
    RegPitchTrim = 3'd2,
    RegYawTrim   = 3'd3,
    RegRollTrim  = 3'd4,
    RegRevLow    = 3'd5,
    RegRevHigh   = 3'd6,
    RegFwdHigh   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ThrDown   = 3'd0,
    ThrPortUp = 3'd1,
    ThrStbdUp = 3'd2,
    ThrPort   = 3'd3,
    ThrStbd   = 3'd4
  } thr_e;

  typedef struct packed {
    logic signed [CmdW-1:0]   base_command;
    logic signed [CmdW-1:0]   forward_trim;
    logic signed [CmdW-1:0]   pitch_trim;
    logic signed [CmdW-1:0]   yaw_trim;
    logic signed [CmdW-1:0]   roll_trim;
    logic signed [RemapW-1:0] reverse_low;
    logic signed [RemapW-1:0] reverse_high;
    logic signed [RemapW-1:0] forward_high;
  } cfg_t;

  typedef struct packed {
    logic signed [CmdW-1:0] ascent;
    logic signed [CmdW-1:0] pitch_cmd;
    logic signed [CmdW-1:0] roll_cmd;
    logic signed [CmdW-1:0] forward_cmd;
    logic signed [CmdW-1:0] yaw_cmd;
  } cmd_t;

  function automatic logic [SpanW-1:0] thr_span(thr_e t);
    logic [SpanW-1:0] s;
    case (t)
      ThrDown:              s = 10'd250;
      ThrPortUp, ThrStbdUp: s = 10'd325;
      ThrPort, ThrStbd:     s = 10'd300;
      default:              s = 10'd250;
    endcase
    return s;
  endfunction

  // floor(2^24 / span)
  function automatic logic [RcpW-1:0] thr_recip(thr_e t);
    logic [RcpW-1:0] r;
    case (t)
      ThrDown:              r = 17'd67108;
      ThrPortUp, ThrStbdUp: r = 17'd51622;
      ThrPort, ThrStbd:     r = 17'd55924;
      default:              r = 17'd67108;
    endcase
    return r;
  endfunction

endpackage

### sv/thmr_mix.sv
module thmr_mix (
  input  thmr_pkg::cfg_t                  cfg_i,
  input  thmr_pkg::cmd_t                  cmd_i,
  input  thmr_pkg::thr_e                  thr_i,
  input  logic                            locked_i,
  output logic signed [thmr_pkg::MixW-1:0] mix_o
);
  import thmr_pkg::*;

  logic signed [MixW-1:0] base, asc, pit, rol, fwd, yaw;
  logic signed [MixW-1:0] ptr, rtr, ftr, ytr;
  logic signed [MixW-1:0] pdiff, half;
  logic signed [MixW-1:0] mix;

  assign base = MixW'(cfg_i.base_command);
  assign ptr  = MixW'(cfg_i.pitch_trim);
  assign rtr  = MixW'(cfg_i.roll_trim);
  assign ftr  = MixW'(cfg_i.forward_trim);
  assign ytr  = MixW'(cfg_i.yaw_trim);
  assign asc  = MixW'(cmd_i.ascent);
  assign pit  = MixW'(cmd_i.pitch_cmd);
  assign rol  = MixW'(cmd_i.roll_cmd);
  assign fwd  = MixW'(cmd_i.forward_cmd);
  assign yaw  = MixW'(cmd_i.yaw_cmd);

  // halve toward zero
  assign pdiff = pit - ptr;
  assign half  = (pdiff + MixW'($signed({1'b0, pdiff[MixW-1]}))) >>> 1;

  always_comb begin
    case (thr_i)
      ThrDown:   mix = base + asc + (pit + ptr);
      ThrPortUp: mix = base - asc + (rol - rtr) - half;
      ThrStbdUp: mix = base - asc + (rol + rtr) - half;
      ThrPort:   mix = base + (fwd - ftr) + (yaw - ytr);
      ThrStbd:   mix = base + (fwd + ftr) - (yaw + ytr);
      default:   mix = '0;
    endcase
  end

  assign mix_o = locked_i ? '0 : mix;

endmodule

### sv/thruster_mix_remap.sv
// Five-thruster mixer with per-drive linear remap. For each command beat,
// each of the five drives passes in turn through the steps of a sequencer
// around a single 25x18 multiplier (mix, slope product, offset product, sum,
// reciprocal multiply, quotient check, correction), and a last step hands the
// five drives to the output register. s_axis_tready is high only while the
// sequencer is idle, so a new beat is not taken until the last one has been
// handed to the output register. A finished result waits there, so the next
// command beat is taken while it is pending; the sequencer holds in its last
// step only while that register is still full.
module thruster_mix_remap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // ascent, pitch_cmd, roll_cmd, forward_cmd, yaw_cmd, lock_flag, zero pad
  input  logic [thmr_pkg::InDataW-1:0]      s_axis_tdata,
  // mode
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // down_drive, port_up_drive, stbd_up_drive, port_drive, stbd_drive
  output logic [thmr_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [thmr_pkg::RemapW-1:0]       cfg_wdata_i
);
  import thmr_pkg::*;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StMix  = 9'b000000010,
    StMa   = 9'b000000100,
    StMb   = 9'b000001000,
    StSum  = 9'b000010000,
    StRcp  = 9'b000100000,
    StChk  = 9'b001000000,
    StFix  = 9'b010000000,
    StDone = 9'b100000000
  } state_e;

  state_e                   state_q;
  thr_e                     thr_q;
  logic                     locked_q;
  cfg_t                     cfg_q;
  cmd_t                     cmd_q;
  logic signed [MixW-1:0]   mix_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  logic                     nsign_q;
  logic [MagW-1:0]          mag_q;
  logic [QuotW-1:0]         q_q;
  logic [OutW-1:0]          res_q [NumThr];
  logic [OutDataW-1:0]      out_data_q;
  logic                     out_valid_q;

  logic signed [MixW-1:0]   mix;
  logic [SpanW-1:0]         span;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic                     neg;
  logic signed [AccW-1:0]   sum;
  logic [RemW-1:0]          rem;
  logic [QuotW:0]           qf;
  logic [OutW-1:0]          res;
  logic                     in_beat;
  logic                     out_free;

  thmr_mix u_mix (
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_q),
    .thr_i    (thr_q),
    .locked_i (locked_q),
    .mix_o    (mix)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign span = thr_span(thr_q);
  assign neg  = mix_q[MixW-1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StMa: begin
        mul_a = neg ? MulAW'(mix_q) + MulAW'($signed({1'b0, span})) : MulAW'(mix_q);
        mul_b = neg ? MulBW'(cfg_q.reverse_high) - MulBW'(cfg_q.reverse_low)
                    : MulBW'(cfg_q.forward_high) - MulBW'(FwdOutLow);
      end
      StMb: begin
        mul_a = MulAW'($signed({1'b0, span}));
        mul_b = neg ? MulBW'(cfg_q.reverse_low) : MulBW'(FwdOutLow);
      end
      StRcp: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({1'b0, thr_recip(thr_q)});
      end
      StChk: begin
        mul_a = $signed({(MulAW-QuotW)'(0), prod_q[RcpShift+QuotW-1:RcpShift]});
        mul_b = $signed({(MulBW-SpanW)'(0), span});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = acc_q + $signed(prod_q[AccW-1:0]);
  assign rem  = {(RemW-MagW)'(0), mag_q} - prod_q[RemW-1:0];
  assign qf   = {1'b0, q_q} + (QuotW+1)'(rem >= {(RemW-SpanW)'(0), span});

  always_comb begin
    if (!nsign_q) begin
      res = (qf > (QuotW+1)'(32767)) ? 16'h7fff : qf[OutW-1:0];
    end else begin
      res = (qf > (QuotW+1)'(32768)) ? 16'h8000 : OutW'(-qf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_command <= '0;
      cfg_q.forward_trim <= '0;
      cfg_q.pitch_trim   <= '0;
      cfg_q.yaw_trim     <= '0;
      cfg_q.roll_trim    <= '0;
      cfg_q.reverse_low  <= -11'sd100;
      cfg_q.reverse_high <= '0;
      cfg_q.forward_high <= 11'sd100;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegBase:      cfg_q.base_command <= $signed(cfg_wdata_i[CmdW-1:0]);
        RegFwdTrim:   cfg_q.forward_trim <= $signed(cfg_wdata_i[CmdW-1:0]);
        RegPitchTrim: cfg_q.pitch_trim   <= $signed(cfg_wdata_i[CmdW-1:0]);
        RegYawTrim:   cfg_q.yaw_trim     <= $signed(cfg_wdata_i[CmdW-1:0]);
        RegRollTrim:  cfg_q.roll_trim    <= $signed(cfg_wdata_i[CmdW-1:0]);
        RegRevLow:    cfg_q.reverse_low  <= $signed(cfg_wdata_i);
        RegRevHigh:   cfg_q.reverse_high <= $signed(cfg_wdata_i);
        RegFwdHigh:   cfg_q.forward_high <= $signed(cfg_wdata_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thr_q       <= ThrDown;
      locked_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            if (s_axis_tuser[0]) begin
              locked_q <= s_axis_tdata[5*CmdW];
            end
            thr_q   <= ThrDown;
            state_q <= StMix;
          end
        end
        StMix: state_q <= StMa;
        StMa:  state_q <= StMb;
        StMb:  state_q <= StSum;
        StSum: state_q <= StRcp;
        StRcp: state_q <= StChk;
        StChk: state_q <= StFix;
        StFix: begin
          if (thr_q == ThrStbd) begin
            state_q <= StDone;
          end else begin
            thr_q   <= thr_e'(thr_q + 3'd1);
            state_q <= StMix;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      if (s_axis_tuser[0]) begin
        cmd_q <= '0;
      end else begin
        cmd_q.ascent      <= $signed(s_axis_tdata[CmdW-1:0]);
        cmd_q.pitch_cmd   <= $signed(s_axis_tdata[2*CmdW-1:CmdW]);
        cmd_q.roll_cmd    <= $signed(s_axis_tdata[3*CmdW-1:2*CmdW]);
        cmd_q.forward_cmd <= $signed(s_axis_tdata[4*CmdW-1:3*CmdW]);
        cmd_q.yaw_cmd     <= $signed(s_axis_tdata[5*CmdW-1:4*CmdW]);
      end
    end
    if (state_q == StMix) begin
      mix_q <= mix;
    end
    if (state_q == StMa || state_q == StMb || state_q == StRcp || state_q == StChk) begin
      prod_q <= prod;
    end
    if (state_q == StMb) begin
      acc_q <= $signed(prod_q[AccW-1:0]);
    end
    if (state_q == StSum) begin
      nsign_q <= sum[AccW-1];
      mag_q   <= MagW'(sum[AccW-1] ? -sum : sum);
    end
    if (state_q == StChk) begin
      q_q <= prod_q[RcpShift+QuotW-1:RcpShift];
    end
    if (state_q == StFix) begin
      res_q[thr_q] <= res;
    end
    if (state_q == StDone && out_free) begin
      out_data_q <= {res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};
    end
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thmr_pkg::*;

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 60;
  localparam int SpanOf [NumThr] = '{250, 325, 325, 300, 300};

  typedef struct packed {
    logic mode;
    logic lock_flag;
    cmd_t cmd;
  } thrust_beat_t;

  typedef logic [NumThr-1:0][OutW-1:0] drive_set_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [2:0]          cfg_idx_i     = '0;
  logic [RemapW-1:0]   cfg_wdata_i   = '0;

  cfg_t       cfg_sh;
  logic       locked_sh;
  drive_set_t drive_q [$];
  int         err_cnt       = 0;
  int         tx_gap_pct    = 30;
  int         rx_stall_pct  = 30;
  int         rx_stall_left = 0;
  int         quiet_cycles  = 0;

  thruster_mix_remap u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [OutW-1:0] remap_drive(longint mix, longint span);
    longint rl, rh, fh, fl, q;
    rl = $signed(cfg_sh.reverse_low);
    rh = $signed(cfg_sh.reverse_high);
    fh = $signed(cfg_sh.forward_high);
    fl = $signed(FwdOutLow);
    if (mix < 0) begin
      q = ((mix + span) * (rh - rl) + rl * span) / span;
    end else begin
      q = (mix * (fh - fl) + fl * span) / span;
    end
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[OutW-1:0];
  endfunction

  function automatic drive_set_t predict_drives(thrust_beat_t b);
    longint asc = 0, pit = 0, rol = 0, fwd = 0, yaw = 0;
    longint base, ftr, ptr, ytr, rtr, half;
    longint mix [NumThr];
    drive_set_t d;
    if (b.mode) begin
      locked_sh = b.lock_flag;
    end else begin
      asc = $signed(b.cmd.ascent);
      pit = $signed(b.cmd.pitch_cmd);
      rol = $signed(b.cmd.roll_cmd);
      fwd = $signed(b.cmd.forward_cmd);
      yaw = $signed(b.cmd.yaw_cmd);
    end
    for (int i = 0; i < NumThr; i++) mix[i] = 0;
    if (!locked_sh) begin
      base = $signed(cfg_sh.base_command);
      ftr  = $signed(cfg_sh.forward_trim);
      ptr  = $signed(cfg_sh.pitch_trim);
      ytr  = $signed(cfg_sh.yaw_trim);
      rtr  = $signed(cfg_sh.roll_trim);
      half = (pit - ptr) / 2;
      mix[ThrDown]   = base + asc + (pit + ptr);
      mix[ThrPortUp] = base - asc + (rol - rtr) - half;
      mix[ThrStbdUp] = base - asc + (rol + rtr) - half;
      mix[ThrPort]   = base + (fwd - ftr) + (yaw - ytr);
      mix[ThrStbd]   = base + (fwd + ftr) - (yaw + ytr);
    end
    for (int i = 0; i < NumThr; i++) d[i] = remap_drive(mix[i], longint'(SpanOf[i]));
    return d;
  endfunction

  function automatic thrust_beat_t cmd_beat(int asc, int pit, int rol, int fwd, int yaw);
    thrust_beat_t b;
    b.mode            = 1'b0;
    b.lock_flag       = 1'($urandom_range(1));
    b.cmd.ascent      = CmdW'(asc);
    b.cmd.pitch_cmd   = CmdW'(pit);
    b.cmd.roll_cmd    = CmdW'(rol);
    b.cmd.forward_cmd = CmdW'(fwd);
    b.cmd.yaw_cmd     = CmdW'(yaw);
    return b;
  endfunction

  function automatic thrust_beat_t rand_beat(int mode_pct, int lock_pct);
    thrust_beat_t b;
    logic [63:0] r;
    r           = {$urandom, $urandom};
    b.cmd       = r[$bits(cmd_t)-1:0];
    b.mode      = ($urandom_range(99) < mode_pct);
    b.lock_flag = ($urandom_range(99) < lock_pct);
    return b;
  endfunction

  function automatic thrust_beat_t lock_beat(logic lk);
    thrust_beat_t b;
    b           = rand_beat(0, 0);
    b.mode      = 1'b1;
    b.lock_flag = lk;
    return b;
  endfunction

  function automatic cfg_t make_cfg(int base, int ftr, int ptr, int ytr, int rtr,
                                    int rl, int rh, int fh);
    cfg_t c;
    c.base_command = CmdW'(base);
    c.forward_trim = CmdW'(ftr);
    c.pitch_trim   = CmdW'(ptr);
    c.yaw_trim     = CmdW'(ytr);
    c.roll_trim    = CmdW'(rtr);
    c.reverse_low  = RemapW'(rl);
    c.reverse_high = RemapW'(rh);
    c.forward_high = RemapW'(fh);
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(cfg_t)-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < 40) $display("%0t ns: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_beat(thrust_beat_t b);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 51){1'b0}}, b.lock_flag, b.cmd.yaw_cmd,
                      b.cmd.forward_cmd, b.cmd.roll_cmd, b.cmd.pitch_cmd, b.cmd.ascent};
    s_axis_tuser  <= b.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    drive_q.push_back(predict_drives(b));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
  endtask

  task automatic program_cfg(cfg_t c);
    reg_idx_e          r;
    logic [RemapW-1:0] v;
    r = r.first();
    repeat (r.num()) begin
      case (r)
        RegBase:      v = {1'($urandom_range(1)), c.base_command};
        RegFwdTrim:   v = {1'($urandom_range(1)), c.forward_trim};
        RegPitchTrim: v = {1'($urandom_range(1)), c.pitch_trim};
        RegYawTrim:   v = {1'($urandom_range(1)), c.yaw_trim};
        RegRollTrim:  v = {1'($urandom_range(1)), c.roll_trim};
        RegRevLow:    v = c.reverse_low;
        RegRevHigh:   v = c.reverse_high;
        default:      v = c.forward_high;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= v;
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
    cfg_sh = c;
  endtask

  task automatic test_lockout_after_reset();
    send_beat(cmd_beat(511, 511, 511, 511, 511));
    send_beat(cmd_beat(-512, -512, -512, -512, -512));
    send_beat(lock_beat(1'b1));
    send_beat(lock_beat(1'b0));
  endtask

  task automatic test_directed_commands();
    send_beat(cmd_beat(0, 0, 0, 0, 0));
    send_beat(cmd_beat(511, 511, 511, 511, 511));
    send_beat(cmd_beat(-512, -512, -512, -512, -512));
    send_beat(cmd_beat(-1, 0, 0, 0, 0));
    send_beat(cmd_beat(0, -3, 0, 0, 0));
    send_beat(cmd_beat(0, 3, 0, 0, 0));
    send_beat(cmd_beat(0, -512, -1, 0, 0));
    send_beat(cmd_beat(0, 0, 0, 511, -512));
    send_beat(cmd_beat(0, 0, 0, -512, 511));
    send_beat(cmd_beat(-512, 0, 511, 0, 0));
    send_beat(lock_beat(1'b1));
    send_beat(cmd_beat(511, -512, 511, -512, 511));
    send_beat(lock_beat(1'b0));
  endtask

  task automatic test_register_extremes();
    cfg_t corners [4];
    corners[0] = make_cfg(511, 511, 511, 511, 511, 1023, 1023, 1023);
    corners[1] = make_cfg(-512, -512, -512, -512, -512, -1024, -1024, -1024);
    corners[2] = make_cfg(0, -512, 511, -512, 511, 1023, -1024, -1024);
    corners[3] = make_cfg(-512, 511, -512, 511, -512, -1000, 1000, 1000);
    foreach (corners[k]) begin
      drain();
      program_cfg(corners[k]);
      tx_gap_pct   = (k == 0) ? 0 : 40;
      rx_stall_pct = (k == 0) ? 0 : 40;
      send_beat(cmd_beat(511, 511, 511, 511, 511));
      send_beat(cmd_beat(-512, -512, -512, -512, -512));
      send_beat(cmd_beat(0, 0, 0, 0, 0));
      send_beat(cmd_beat(-1, 1, -1, 1, -1));
      repeat (8) send_beat(rand_beat(10, 30));
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      program_cfg(rand_cfg());
      case (ph)
        0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_gap_pct = 70; rx_stall_pct = 70; end
        2:       begin tx_gap_pct = 0;  rx_stall_pct = 60; end
        3:       begin tx_gap_pct = 60; rx_stall_pct = 0;  end
        default: begin tx_gap_pct = 30; rx_stall_pct = 30; end
      endcase
      repeat (150) send_beat(rand_beat(8, 30));
    end
  endtask

  always @(posedge clk_i) begin : rx_ready_gen
    int n;
    if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      n = pick_gap(rx_stall_pct);
      if (n == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall_left = n - 1;
      end
    end
  end

  always @(posedge clk_i) begin : check_drives
    drive_set_t got, want;
    thr_e       t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (drive_q.size() == 0) begin
        report_mismatch("result beat with no command pending");
      end else begin
        want = drive_q.pop_front();
        for (int i = 0; i < NumThr; i++) begin
          t = thr_e'(i);
          if (got[i] !== want[i]) begin
            report_mismatch($sformatf("%s got %0d expected %0d", t.name(),
                                      $signed(got[i]), $signed(want[i])));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cfg_sh    = make_cfg(0, 0, 0, 0, 0, -100, 0, 100);
    locked_sh = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_lockout_after_reset();
    test_directed_commands();
    test_register_extremes();
    test_random_traffic();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
